// ----- hdl/tep_pkg.sv -----
package tep_pkg;

	// Default sizes of the parser
	localparam int unsigned MAX_ENTRIES_DEF = 1024;
	localparam int unsigned HASH_BYTES_DEF  = 32;
	localparam int unsigned NAME_LIMIT_DEF  = 256;

	// Fixed field widths
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned MODE_W      = 32;
	localparam int unsigned COUNT_OUT_W = 11;
	localparam int unsigned MODE_CNT_W  = 5;
	localparam int unsigned IN_DATA_W   = 8;
	localparam int unsigned OUT_DATA_W  = 56;

	// Mode field may hold at most this many bytes minus one
	localparam logic [MODE_CNT_W-1:0] MODE_FIELD_LIMIT = 5'd16;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

	// Mode scanner stage
	typedef enum logic [1:0] {
		SCAN_SKIP   = 2'd0,
		SCAN_DIGITS = 2'd1,
		SCAN_STOP   = 2'd2
	} scan_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_SILENT = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_HASH   = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	// Mode scanner state
	typedef struct packed {
		scan_t              stage;
		logic               neg;
		logic [MODE_W-1:0]  acc;
	} mode_scan_t;

	// One result item
	typedef struct packed {
		kind_t                   kind;
		logic [BYTE_W-1:0]       byte_out;
		logic                    entry_done;
		logic [MODE_W-1:0]       entry_mode;
		logic                    parse_status;
		logic [COUNT_OUT_W-1:0]  entries_parsed;
	} result_t;

endpackage

// ----- hdl/tep_mode_scan.sv -----
module tep_mode_scan (
	input  tep_pkg::mode_scan_t        cur,
	input  logic [tep_pkg::BYTE_W-1:0] data_byte,
	output tep_pkg::mode_scan_t        nxt
);

	logic is_ws;
	logic is_digit;

	assign is_ws    = (data_byte >= tep_pkg::CHAR_TAB) && (data_byte <= tep_pkg::CHAR_CR);
	assign is_digit = (data_byte >= tep_pkg::CHAR_ZERO) && (data_byte <= tep_pkg::CHAR_SEVEN);

	// strtol-style base 8 scan, one byte per step
	always_comb begin
		nxt = cur;
		priority if (cur.stage == tep_pkg::SCAN_SKIP && is_ws) begin
			nxt = cur;
		end else if (cur.stage == tep_pkg::SCAN_SKIP && data_byte == tep_pkg::CHAR_PLUS) begin
			nxt.stage = tep_pkg::SCAN_DIGITS;
		end else if (cur.stage == tep_pkg::SCAN_SKIP && data_byte == tep_pkg::CHAR_MINUS) begin
			nxt.neg   = 1'b1;
			nxt.stage = tep_pkg::SCAN_DIGITS;
		end else if (cur.stage != tep_pkg::SCAN_STOP && is_digit) begin
			// digit value is the low three bits of '0'..'7'
			nxt.acc   = {cur.acc[tep_pkg::MODE_W-4:0], data_byte[2:0]};
			nxt.stage = tep_pkg::SCAN_DIGITS;
		end else begin
			nxt.stage = tep_pkg::SCAN_STOP;
		end
	end

endmodule

// ----- hdl/tep_parser.sv -----
module tep_parser #(
	parameter int unsigned MAX_ENTRIES = tep_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned HASH_BYTES  = tep_pkg::HASH_BYTES_DEF,
	parameter int unsigned NAME_LIMIT  = tep_pkg::NAME_LIMIT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       action,
	input  logic [tep_pkg::BYTE_W-1:0] data_byte,
	output tep_pkg::result_t           res
);

	localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned NAME_W = $clog2(NAME_LIMIT + 1);
	localparam int unsigned HASH_W = $clog2(HASH_BYTES + 1);
	localparam int unsigned EXT_W  = CNT_W + tep_pkg::COUNT_OUT_W;

	typedef enum logic [1:0] {
		PH_MODE = 2'd0,
		PH_NAME = 2'd1,
		PH_HASH = 2'd2
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [tep_pkg::MODE_CNT_W-1:0]  mode_cnt_q, mode_cnt_d, mode_inc;
	tep_pkg::mode_scan_t             scan_q, scan_d, scan_nxt;
	logic [NAME_W-1:0]               name_cnt_q, name_cnt_d, name_inc;
	logic [HASH_W-1:0]               hash_idx_q, hash_idx_d, hash_inc;
	logic [CNT_W-1:0]                entry_cnt_q, entry_cnt_d, entry_inc, cnt_show;
	logic [EXT_W-1:0]                cnt_ext;
	logic                            error_q, error_d;
	logic                            below_max;
	logic                            mid_entry;

	tep_mode_scan u_scan (
		.cur       (scan_q),
		.data_byte (data_byte),
		.nxt       (scan_nxt)
	);

	assign mode_inc  = mode_cnt_q + 1'b1;
	assign name_inc  = name_cnt_q + 1'b1;
	assign hash_inc  = hash_idx_q + 1'b1;
	assign entry_inc = entry_cnt_q + 1'b1;
	assign below_max = entry_cnt_q < CNT_W'(MAX_ENTRIES);
	assign mid_entry = (phase_q != PH_MODE) || (mode_cnt_q != '0);
	assign cnt_ext   = {{tep_pkg::COUNT_OUT_W{1'b0}}, cnt_show};

	// Next state and result for the item in the input register
	always_comb begin
		phase_d     = phase_q;
		mode_cnt_d  = mode_cnt_q;
		scan_d      = scan_q;
		name_cnt_d  = name_cnt_q;
		hash_idx_d  = hash_idx_q;
		entry_cnt_d = entry_cnt_q;
		error_d     = error_q;
		cnt_show    = entry_cnt_q;
		res         = '0;
		res.kind    = tep_pkg::KIND_SILENT;

		if (action) begin
			// end of buffer: report, then back to reset state
			res.kind         = tep_pkg::KIND_END;
			res.parse_status = error_q | (below_max & mid_entry);
			phase_d          = PH_MODE;
			mode_cnt_d       = '0;
			scan_d           = '0;
			scan_d.stage     = tep_pkg::SCAN_SKIP;
			name_cnt_d       = '0;
			hash_idx_d       = '0;
			entry_cnt_d      = '0;
			error_d          = 1'b0;
		end else if (!error_q && below_max) begin
			unique case (phase_q)
				PH_MODE: begin
					if (data_byte == tep_pkg::CHAR_SPACE) begin
						phase_d = PH_NAME;
					end else begin
						mode_cnt_d = mode_inc;
						if (mode_inc >= tep_pkg::MODE_FIELD_LIMIT) begin
							error_d = 1'b1;
						end else begin
							scan_d = scan_nxt;
						end
					end
				end
				PH_NAME: begin
					if (data_byte == tep_pkg::CHAR_NUL) begin
						phase_d = PH_HASH;
					end else begin
						name_cnt_d = name_inc;
						if (name_inc == NAME_W'(NAME_LIMIT)) begin
							error_d = 1'b1;
						end else begin
							res.kind     = tep_pkg::KIND_NAME;
							res.byte_out = data_byte;
						end
					end
				end
				PH_HASH: begin
					res.kind     = tep_pkg::KIND_HASH;
					res.byte_out = data_byte;
					hash_idx_d   = hash_inc;
					if (hash_inc == HASH_W'(HASH_BYTES)) begin
						// last hash byte closes the entry
						entry_cnt_d    = entry_inc;
						cnt_show       = entry_inc;
						res.entry_done = 1'b1;
						res.entry_mode = scan_q.neg ? (tep_pkg::MODE_W'(0) - scan_q.acc)
						                            : scan_q.acc;
						phase_d        = PH_MODE;
						mode_cnt_d     = '0;
						scan_d         = '0;
						scan_d.stage   = tep_pkg::SCAN_SKIP;
						name_cnt_d     = '0;
						hash_idx_d     = '0;
					end
				end
				default: begin
					phase_d = PH_MODE;
				end
			endcase
		end

		if (action || res.entry_done) begin
			res.entries_parsed = cnt_ext[tep_pkg::COUNT_OUT_W-1:0];
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MODE;
			mode_cnt_q   <= '0;
			scan_q       <= '0;
			name_cnt_q   <= '0;
			hash_idx_q   <= '0;
			entry_cnt_q  <= '0;
			error_q      <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			mode_cnt_q   <= mode_cnt_d;
			scan_q       <= scan_d;
			name_cnt_q   <= name_cnt_d;
			hash_idx_q   <= hash_idx_d;
			entry_cnt_q  <= entry_cnt_d;
			error_q      <= error_d;
		end
	end

	// End report leaves the parser in its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && action) |=> (entry_cnt_q == '0 && !error_q && phase_q == PH_MODE
		                      && mode_cnt_q == '0))
		else $error("parser state not cleared after end report");

	// Error holds until an end item
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(error_q && !(step && action)) |=> error_q)
		else $error("error flag dropped without end report");

	// Entry count never passes its limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond limit");

	// Hash index wraps before reaching the hash length
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		hash_idx_q < HASH_W'(HASH_BYTES))
		else $error("hash index out of range");

	// Entry close only comes out of the hash phase
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.entry_done) |-> (phase_q == PH_HASH && !error_q))
		else $error("entry closed outside hash phase");

endmodule

// ----- hdl/tree_object_entry_parser_top.sv -----
// Flow: input register, then parse logic, then result register driving m_tdata.
//   The parse state update of one byte sets the clock path.
// Throughput: one item per cycle while m_tready does not stall the output.
// Reset: arst_n clears both stage valid flags and the parse state (mode field, counts zero,
//   no error); payload registers are not reset.
module tree_object_entry_parser_top #(
	parameter int unsigned MAX_ENTRIES = tep_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned HASH_BYTES  = tep_pkg::HASH_BYTES_DEF,
	parameter int unsigned NAME_LIMIT  = tep_pkg::NAME_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tep_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic                            s_tuser,   // [0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tep_pkg::OUT_DATA_W-1:0]  m_tdata,   // [7:0] byte_out, [39:8] entry_mode,
	                                                   // [40] parse_status,
	                                                   // [51:41] entries_parsed, [55:52] zero
	output logic                            m_tlast,   // entry_done
	output logic [1:0]                      m_tuser    // [1:0] kind
);

	logic                        valid_s1;
	logic                        action_s1;
	logic [tep_pkg::BYTE_W-1:0]  byte_s1;
	logic                        valid_s2;
	tep_pkg::result_t            res_s2;
	tep_pkg::result_t            res;
	logic                        out_free;
	logic                        step;

	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input and result payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata[tep_pkg::BYTE_W-1:0];
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	tep_parser #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.HASH_BYTES  (HASH_BYTES),
		.NAME_LIMIT  (NAME_LIMIT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.action    (action_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	// Output packing
	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.entry_done;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {4'b0000, res_s2.entries_parsed, res_s2.parse_status,
	                   res_s2.entry_mode, res_s2.byte_out};

endmodule

// ----- sim/tree_object_entry_parser_top_tb.sv -----
module tree_object_entry_parser_top_tb;

	localparam int unsigned MAX_ENT  = tep_pkg::MAX_ENTRIES_DEF;
	localparam int unsigned HASH_N   = tep_pkg::HASH_BYTES_DEF;
	localparam int unsigned NAME_LIM = tep_pkg::NAME_LIMIT_DEF;
	localparam int unsigned HOLD_CYC = 200;
	localparam int unsigned DRAIN_CYC = 8;
	localparam int unsigned MAX_SHOWN = 50;

	// Where the predictor is inside one entry
	typedef enum logic [1:0] {
		PH_MODE = 2'd0,
		PH_NAME = 2'd1,
		PH_HASH = 2'd2
	} entry_phase_t;

	// One input item: action flag and raw byte
	typedef struct packed {
		logic                       end_of_buf;
		logic [tep_pkg::BYTE_W-1:0] data;
	} obj_item_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [tep_pkg::IN_DATA_W-1:0]     s_tdata = '0;
	logic                              s_tuser = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [tep_pkg::OUT_DATA_W-1:0]    m_tdata;
	logic                              m_tlast;
	logic [1:0]                        m_tuser;

	tree_object_entry_parser_top #(
		.MAX_ENTRIES(MAX_ENT),
		.HASH_BYTES (HASH_N),
		.NAME_LIMIT (NAME_LIM)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and expectations
	obj_item_t                   object_bytes[$];
	tep_pkg::result_t            expected_results[$];
	logic [tep_pkg::BYTE_W-1:0]  entry_bytes[$];
	int unsigned        bytes_queued = 0;
	int unsigned        bytes_taken = 0;
	int unsigned        n_err = 0;
	int unsigned        send_idle_pct = 0;
	int unsigned        rx_stall_pct = 0;
	logic               hold_go = 1'b0;
	int unsigned        hold_left = 0;

	// Predictor state
	entry_phase_t                    ps_phase;
	logic [tep_pkg::MODE_CNT_W-1:0]  ps_mode_cnt;
	tep_pkg::scan_t                  ps_stage;
	logic                            ps_neg;
	logic [tep_pkg::MODE_W-1:0]      ps_acc;
	logic [12:0]        ps_name_cnt;
	logic [6:0]         ps_hash_idx;
	logic [16:0]        ps_entries;
	logic               ps_err;

	function automatic void start_new_entry();
		ps_phase    = PH_MODE;
		ps_mode_cnt = '0;
		ps_stage    = tep_pkg::SCAN_SKIP;
		ps_neg      = 1'b0;
		ps_acc      = '0;
		ps_name_cnt = '0;
		ps_hash_idx = '0;
	endfunction

	// Expected result of one accepted item; advances the predictor state
	function automatic tep_pkg::result_t tree_parse_step(logic end_of_buf,
		logic [tep_pkg::BYTE_W-1:0] b);
		tep_pkg::result_t r;
		logic    is_dig;
		logic    is_ws;
		r      = '0;
		is_dig = (b >= tep_pkg::CHAR_ZERO) && (b <= tep_pkg::CHAR_SEVEN);
		is_ws  = (b >= tep_pkg::CHAR_TAB) && (b <= tep_pkg::CHAR_CR);
		if (end_of_buf) begin
			// end inside an unfinished entry is malformed, unless the limit was hit
			if (ps_entries < MAX_ENT && (ps_phase != PH_MODE || ps_mode_cnt != 0))
				ps_err = 1'b1;
			r.kind           = tep_pkg::KIND_END;
			r.parse_status   = ps_err;
			r.entries_parsed = ps_entries[tep_pkg::COUNT_OUT_W-1:0];
			start_new_entry();
			ps_entries = '0;
			ps_err     = 1'b0;
		end else if (!ps_err && ps_entries < MAX_ENT) begin
			case (ps_phase)
				PH_MODE: begin
					if (b == tep_pkg::CHAR_SPACE) begin
						ps_phase = PH_NAME;
					end else begin
						ps_mode_cnt = ps_mode_cnt + 1'b1;
						if (ps_mode_cnt >= tep_pkg::MODE_FIELD_LIMIT)
							ps_err = 1'b1;
						else if (ps_stage != tep_pkg::SCAN_STOP && b == tep_pkg::CHAR_NUL)
							ps_stage = tep_pkg::SCAN_STOP;
						else if (ps_stage == tep_pkg::SCAN_SKIP && is_ws)
							ps_stage = tep_pkg::SCAN_SKIP;
						else if (ps_stage == tep_pkg::SCAN_SKIP && b == tep_pkg::CHAR_PLUS)
							ps_stage = tep_pkg::SCAN_DIGITS;
						else if (ps_stage == tep_pkg::SCAN_SKIP && b == tep_pkg::CHAR_MINUS) begin
							ps_neg   = 1'b1;
							ps_stage = tep_pkg::SCAN_DIGITS;
						end else if (ps_stage != tep_pkg::SCAN_STOP && is_dig) begin
							ps_acc   = (ps_acc << 3) + tep_pkg::MODE_W'(b - tep_pkg::CHAR_ZERO);
							ps_stage = tep_pkg::SCAN_DIGITS;
						end else
							ps_stage = tep_pkg::SCAN_STOP;
					end
				end
				PH_NAME: begin
					if (b == tep_pkg::CHAR_NUL) begin
						ps_phase = PH_HASH;
					end else begin
						ps_name_cnt = ps_name_cnt + 1'b1;
						if (ps_name_cnt >= NAME_LIM)
							ps_err = 1'b1;
						else begin
							r.kind     = tep_pkg::KIND_NAME;
							r.byte_out = b;
						end
					end
				end
				default: begin
					r.kind      = tep_pkg::KIND_HASH;
					r.byte_out  = b;
					ps_hash_idx = ps_hash_idx + 1'b1;
					if (ps_hash_idx >= HASH_N) begin
						ps_entries       = ps_entries + 1'b1;
						r.entry_done     = 1'b1;
						r.entry_mode     = ps_neg ? (tep_pkg::MODE_W'(0) - ps_acc) : ps_acc;
						r.entries_parsed = ps_entries[tep_pkg::COUNT_OUT_W-1:0];
						start_new_entry();
					end
				end
			endcase
		end
		return r;
	endfunction

	// Sender: offers queued items, holds while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(tree_parse_step(s_tuser, s_tdata));
				bytes_taken++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (object_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser  <= object_bytes[0].end_of_buf;
					s_tdata  <= object_bytes[0].data;
					void'(object_bytes.pop_front());
				end else begin
					s_tvalid <= 1'b0;
					s_tuser  <= 1'($urandom);
					s_tdata  <= tep_pkg::IN_DATA_W'($urandom);
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_go) begin
			hold_left <= HOLD_CYC;
			hold_go   <= 1'b0;
		end
	end

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (n_err < MAX_SHOWN)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			n_err++;
		end
	endtask

	// Receiver: checks each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					if (n_err < MAX_SHOWN)
						$display("%0t: unexpected result, got %h", $time, m_tdata);
					n_err++;
				end else begin
					check_field("kind", expected_results[0].kind, m_tuser);
					check_field("byte_out", expected_results[0].byte_out, m_tdata[7:0]);
					check_field("entry_done", expected_results[0].entry_done, m_tlast);
					check_field("entry_mode", expected_results[0].entry_mode, m_tdata[39:8]);
					check_field("parse_status", expected_results[0].parse_status,
						m_tdata[40]);
					check_field("entries_parsed", expected_results[0].entries_parsed,
						m_tdata[51:41]);
					void'(expected_results.pop_front());
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic put(logic end_of_buf, logic [tep_pkg::BYTE_W-1:0] b);
		obj_item_t it;
		it.end_of_buf = end_of_buf;
		it.data       = b;
		object_bytes.push_back(it);
		bytes_queued++;
	endtask

	function automatic logic [tep_pkg::BYTE_W-1:0] not_space();
		logic [tep_pkg::BYTE_W-1:0] b;
		b = tep_pkg::BYTE_W'($urandom);
		return (b == tep_pkg::CHAR_SPACE) ? tep_pkg::CHAR_PLUS : b;
	endfunction

	// Builds one entry into entry_bytes; it is well-formed unless n_name reaches the name limit
	task automatic build_entry(int unsigned n_name);
		int unsigned n_dig;
		int unsigned sel;
		entry_bytes.delete();
		// mode: optional whitespace, sign, octal digits, stray tail
		if ($urandom_range(9) < 2)
			repeat ($urandom_range(1, 2))
				entry_bytes.push_back(tep_pkg::BYTE_W'($urandom_range(tep_pkg::CHAR_TAB,
					tep_pkg::CHAR_CR)));
		sel = $urandom_range(9);
		if (sel < 2)
			entry_bytes.push_back(tep_pkg::CHAR_MINUS);
		else if (sel == 2)
			entry_bytes.push_back(tep_pkg::CHAR_PLUS);
		n_dig = ($urandom_range(9) < 2) ? $urandom_range(8, 12) : $urandom_range(0, 6);
		repeat (n_dig)
			entry_bytes.push_back(tep_pkg::CHAR_ZERO + tep_pkg::BYTE_W'($urandom_range(7)));
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(3))
				0: entry_bytes.push_back(tep_pkg::CHAR_NUL);
				1: entry_bytes.push_back(tep_pkg::CHAR_SEVEN + 8'd1);
				2: entry_bytes.push_back(tep_pkg::CHAR_MINUS);
				default: entry_bytes.push_back(not_space());
			endcase
			if ($urandom_range(1))
				entry_bytes.push_back(tep_pkg::CHAR_ZERO + tep_pkg::BYTE_W'($urandom_range(7)));
		end
		while (entry_bytes.size() >= tep_pkg::MODE_FIELD_LIMIT)
			void'(entry_bytes.pop_back());
		entry_bytes.push_back(tep_pkg::CHAR_SPACE);
		repeat (n_name)
			entry_bytes.push_back(tep_pkg::BYTE_W'($urandom_range(1, 255)));
		entry_bytes.push_back(tep_pkg::CHAR_NUL);
		repeat (HASH_N)
			entry_bytes.push_back(tep_pkg::BYTE_W'($urandom));
	endtask

	task automatic put_entry_bytes(int unsigned n);
		for (int unsigned i = 0; i < n && i < entry_bytes.size(); i++)
			put(1'b0, entry_bytes[i]);
	endtask

	function automatic int unsigned pick_name_len();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return $urandom_range(0, 8);
		else if (sel < 97)
			return $urandom_range(9, 40);
		return $urandom_range(NAME_LIM - 40, NAME_LIM - 1);
	endfunction

	// One buffer: some good entries, then a clean or broken ending
	task automatic put_buffer();
		int unsigned sel;
		repeat ($urandom_range(0, 3)) begin
			build_entry(pick_name_len());
			put_entry_bytes(entry_bytes.size());
		end
		sel = $urandom_range(99);
		if (sel < 55) begin
			// clean end
		end else if (sel < 70) begin
			build_entry(pick_name_len());
			put_entry_bytes($urandom_range(1, entry_bytes.size() - 1));
		end else if (sel < 78) begin
			repeat (tep_pkg::MODE_FIELD_LIMIT + $urandom_range(0, 3))
				put(1'b0, not_space());
			repeat ($urandom_range(0, 3))
				put(1'b0, tep_pkg::BYTE_W'($urandom));
		end else if (sel < 82) begin
			build_entry(NAME_LIM + $urandom_range(0, 2));
			put_entry_bytes(entry_bytes.size());
		end else if (sel < 92) begin
			repeat ($urandom_range(1, 30))
				put(1'b0, tep_pkg::BYTE_W'($urandom));
		end else
			put(1'b1, '0);
		put(1'b1, '0);
	endtask

	task automatic wait_drained();
		while (bytes_taken != bytes_queued || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_bytes);
		int unsigned goal;
		wait_drained();
		send_idle_pct = idle;
		rx_stall_pct  = stall;
		goal = bytes_queued + n_bytes;
		while (bytes_queued < goal)
			put_buffer();
	endtask

	initial begin
		start_new_entry();
		ps_entries = '0;
		ps_err     = 1'b0;

		// empty buffer
		put(1'b1, '0);
		// sign and digits, cut off in the hash
		put(1'b0, tep_pkg::CHAR_MINUS);
		put(1'b0, tep_pkg::CHAR_ZERO + 8'd1);
		put(1'b0, tep_pkg::CHAR_SEVEN);
		put(1'b0, tep_pkg::CHAR_SPACE);
		put(1'b0, tep_pkg::CHAR_NUL);
		put(1'b1, '0);
		// plus sign, cut off in the name
		put(1'b0, tep_pkg::CHAR_PLUS);
		put(1'b0, tep_pkg::CHAR_SPACE);
		put(1'b1, 8'hFF);
		// mode field too long
		repeat (tep_pkg::MODE_FIELD_LIMIT)
			put(1'b0, tep_pkg::CHAR_SEVEN);
		put(1'b1, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no idling, with one long receiver hold-off
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		while (bytes_queued < 330)
			put_buffer();
		@(posedge clk);
		hold_go <= 1'b1;

		run_phase(77, 0, 300);
		run_phase(0, 77, 300);
		run_phase(28, 28, 320);

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (n_err == 0)
			$display("tree_object_entry_parser_top_tb OK");
		else
			$display("tree_object_entry_parser_top_tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tree_object_entry_parser_top_tb NOT OK");
		$finish;
	end

endmodule

// ----- tree_object_entry_parser_top.f -----
hdl/tep_pkg.sv
hdl/tep_mode_scan.sv
hdl/tep_parser.sv
hdl/tree_object_entry_parser_top.sv
sim/tree_object_entry_parser_top_tb.sv
